[hw/rtl/tga_pkg.sv]
// Shared types and codes for the TGA run-length stream decoder.
`default_nettype none

package tga_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } tga_in_t;

  typedef struct packed {
    logic [23:0] pixel_value;
    logic [7:0]  run_length;
    logic        end_of_row;
    logic        packet_overrun;
    logic [1:0]  error_code;
    logic        last;
  } tga_out_t;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_ID     = 5'b00010,
    PH_PACKET = 5'b00100,
    PH_PIXEL  = 5'b01000,
    PH_DONE   = 5'b10000
  } tga_phase_t;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TYPE  = 2'd1;
  localparam logic [1:0] ERR_DEPTH = 2'd2;

  localparam logic [7:0] TYPE_TRUE     = 8'd2;
  localparam logic [7:0] TYPE_GRAY     = 8'd3;
  localparam logic [7:0] TYPE_RLE_TRUE = 8'd10;
  localparam logic [7:0] TYPE_RLE_GRAY = 8'd11;

  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_8  = 8'd8;

  localparam logic [4:0] HDR_ID_LEN   = 5'd0;
  localparam logic [4:0] HDR_TYPE     = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH    = 5'd16;
  localparam logic [4:0] HDR_LAST     = 5'd17;

endpackage

`default_nettype wire

[hw/rtl/tga_out_skid.sv]
// Two-entry output stage (main register plus skid register) for decoder results.
`default_nettype none

module tga_out_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  input  wire tga_pkg::tga_out_t up_data,
  output logic                   up_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tga_pkg::tga_out_t      out_data
);
  import tga_pkg::*;

  logic     main_v_r, main_v_nxt;
  logic     skid_v_r, skid_v_nxt;
  tga_out_t main_d_r, main_d_nxt;
  tga_out_t skid_d_r, skid_d_nxt;

  assign up_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (main_v_r && !out_ready) begin
      // hold the waiting result, park a new one in the skid slot
      if (up_valid && !skid_v_r) begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = up_data;
      end
    end else if (skid_v_r) begin
      main_v_nxt = 1'b1;
      main_d_nxt = skid_d_r;
      skid_v_nxt = 1'b0;
    end else begin
      main_v_nxt = up_valid;
      main_d_nxt = up_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/tga_rle_stream_decoder.sv]
// Top level of the TGA run-length stream decoder.
// Takes one file byte per cycle (first_byte restarts parsing at a header) and turns the
// 18-byte header, the image-ID skip and the pixel data of 24-bit true-color or 8-bit
// grayscale images, plain or RLE, into runs of RGB pixel value and repeat count. Each byte
// is one state update, so a byte is accepted every cycle; its result, if any, is registered
// in a two-entry output stage, and input stalls only once both entries hold
// results that the consumer has not taken. Unsupported types and depths give one error
// result; an empty image gives one result with run_length 0 and last set.
`default_nettype none

module tga_rle_stream_decoder (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tga_pkg::tga_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tga_pkg::tga_out_t     out_data
);
  import tga_pkg::*;

  tga_phase_t  phase_r, phase_nxt, cur_phase;
  logic [4:0]  hidx_r, hidx_nxt, cur_hidx;
  logic [7:0]  id_left_r, id_left_nxt, cur_id_left;
  logic [7:0]  type_r, type_nxt, cur_type;
  logic [1:0]  bpp_r, bpp_nxt, cur_bpp;
  logic [15:0] width_r, width_nxt, cur_width;
  logic [15:0] height_r, height_nxt, cur_height;
  logic [16:0] col_r, col_nxt, cur_col;
  logic [15:0] row_r, row_nxt, cur_row;
  logic [7:0]  raw_left_r, raw_left_nxt, cur_raw_left;
  logic [7:0]  rep_cnt_r, rep_cnt_nxt, cur_rep_cnt;
  logic        is_rep_r, is_rep_nxt, cur_is_rep;
  logic [1:0]  pbi_r, pbi_nxt, cur_pbi;
  logic [23:0] asm_r, asm_nxt, cur_asm;

  logic        accept;
  logic        res_v;
  tga_out_t    res;
  logic [7:0]  b;
  logic        is_rle, type_ok, depth_bad, do_begin, packet_done, eor, row_last;
  logic [7:0]  cnt, run;
  logic [23:0] asm_new;
  logic [1:0]  pbi_new;
  logic [16:0] col_new;
  logic [15:0] row_new;
  logic [7:0]  raw_dec;

  assign accept = in_valid && in_ready;
  assign b      = in_data.data_byte;

  always_comb begin
    cur_phase    = phase_r;
    cur_hidx     = hidx_r;
    cur_id_left  = id_left_r;
    cur_type     = type_r;
    cur_bpp      = bpp_r;
    cur_width    = width_r;
    cur_height   = height_r;
    cur_col      = col_r;
    cur_row      = row_r;
    cur_raw_left = raw_left_r;
    cur_rep_cnt  = rep_cnt_r;
    cur_is_rep   = is_rep_r;
    cur_pbi      = pbi_r;
    cur_asm      = asm_r;
    // first byte of a file: restart from the reset state
    if (in_data.first_byte) begin
      cur_phase    = PH_HEADER;
      cur_hidx     = '0;
      cur_id_left  = '0;
      cur_type     = '0;
      cur_bpp      = '0;
      cur_width    = '0;
      cur_height   = '0;
      cur_col      = '0;
      cur_row      = '0;
      cur_raw_left = '0;
      cur_rep_cnt  = '0;
      cur_is_rep   = 1'b0;
      cur_pbi      = '0;
      cur_asm      = '0;
    end
  end

  assign is_rle  = (cur_type == TYPE_RLE_TRUE) || (cur_type == TYPE_RLE_GRAY);
  assign type_ok = (cur_type == TYPE_TRUE) || (cur_type == TYPE_GRAY) || is_rle;
  assign depth_bad = (((cur_type == TYPE_TRUE) || (cur_type == TYPE_RLE_TRUE)) &&
                      (cur_bpp != 2'd3)) ||
                     (((cur_type == TYPE_GRAY) || (cur_type == TYPE_RLE_GRAY)) &&
                      (cur_bpp != 2'd1));
  assign cnt     = {1'b0, b[6:0]} + 8'd1;
  assign pbi_new = cur_pbi + 2'd1;
  assign raw_dec = cur_raw_left - 8'd1;
  assign run     = cur_is_rep ? cur_rep_cnt : 8'd1;
  assign col_new = cur_col + {9'd0, run};
  assign eor     = col_new >= {1'b0, cur_width};
  assign row_new = cur_row + 16'd1;
  assign row_last = row_new >= cur_height;
  assign packet_done = cur_is_rep || !is_rle || (raw_dec == 8'd0);

  always_comb begin
    case (cur_pbi)
      2'd0:    asm_new = cur_asm | {16'd0, b};
      2'd1:    asm_new = cur_asm | {8'd0, b, 8'd0};
      2'd2:    asm_new = cur_asm | {b, 16'd0};
      default: asm_new = cur_asm;
    endcase
  end

  always_comb begin
    phase_nxt    = cur_phase;
    hidx_nxt     = cur_hidx;
    id_left_nxt  = cur_id_left;
    type_nxt     = cur_type;
    bpp_nxt      = cur_bpp;
    width_nxt    = cur_width;
    height_nxt   = cur_height;
    col_nxt      = cur_col;
    row_nxt      = cur_row;
    raw_left_nxt = cur_raw_left;
    rep_cnt_nxt  = cur_rep_cnt;
    is_rep_nxt   = cur_is_rep;
    pbi_nxt      = cur_pbi;
    asm_nxt      = cur_asm;
    res_v        = 1'b0;
    res          = '0;
    do_begin     = 1'b0;

    case (cur_phase)
      PH_HEADER: begin
        hidx_nxt = cur_hidx + 5'd1;
        case (cur_hidx)
          HDR_ID_LEN:    id_left_nxt = b;
          HDR_TYPE:      type_nxt = b;
          HDR_WIDTH_LO:  width_nxt = {cur_width[15:8], b};
          HDR_WIDTH_HI:  width_nxt = {b, cur_width[7:0]};
          HDR_HEIGHT_LO: height_nxt = {cur_height[15:8], b};
          HDR_HEIGHT_HI: height_nxt = {b, cur_height[7:0]};
          HDR_DEPTH:     bpp_nxt = (b == DEPTH_24) ? 2'd3 : ((b == DEPTH_8) ? 2'd1 : 2'd0);
          default: ;
        endcase
        if (cur_hidx >= HDR_LAST) begin
          hidx_nxt = '0;
          if (!type_ok) begin
            phase_nxt      = PH_DONE;
            res_v          = 1'b1;
            res.error_code = ERR_TYPE;
            res.last       = 1'b1;
          end else if (depth_bad) begin
            phase_nxt      = PH_DONE;
            res_v          = 1'b1;
            res.error_code = ERR_DEPTH;
            res.last       = 1'b1;
          end else if (cur_id_left != 8'd0) begin
            phase_nxt = PH_ID;
          end else begin
            do_begin = 1'b1;
          end
        end
      end
      PH_ID: begin
        id_left_nxt = cur_id_left - 8'd1;
        if (id_left_nxt == 8'd0) do_begin = 1'b1;
      end
      PH_PACKET: begin
        if (b[7]) begin
          is_rep_nxt  = 1'b1;
          rep_cnt_nxt = cnt;
        end else begin
          is_rep_nxt   = 1'b0;
          raw_left_nxt = cnt;
        end
        pbi_nxt   = '0;
        asm_nxt   = '0;
        phase_nxt = PH_PIXEL;
      end
      PH_PIXEL: begin
        pbi_nxt = pbi_new;
        asm_nxt = asm_new;
        if (pbi_new >= cur_bpp) begin
          pbi_nxt = '0;
          asm_nxt = '0;
          if (!cur_is_rep && is_rle) raw_left_nxt = raw_dec;
          col_nxt            = col_new;
          res_v              = 1'b1;
          res.pixel_value    = asm_new;
          res.run_length     = run;
          res.end_of_row     = eor;
          res.packet_overrun = col_new > {1'b0, cur_width};
          res.error_code     = ERR_NONE;
          if (packet_done) begin
            // wrap to column 0 and drop any overshoot past the row end
            if (eor) begin
              col_nxt  = '0;
              row_nxt  = row_new;
              res.last = row_last;
            end
            if (eor && row_last) phase_nxt = PH_DONE;
            else phase_nxt = is_rle ? PH_PACKET : PH_PIXEL;
          end
        end
      end
      default: ;
    endcase

    if (do_begin) begin
      col_nxt      = '0;
      row_nxt      = '0;
      pbi_nxt      = '0;
      asm_nxt      = '0;
      is_rep_nxt   = 1'b0;
      raw_left_nxt = '0;
      rep_cnt_nxt  = '0;
      if ((cur_width == 16'd0) || (cur_height == 16'd0)) begin
        phase_nxt = PH_DONE;
        res_v     = 1'b1;
        res       = '0;
        res.last  = 1'b1;
      end else begin
        phase_nxt = is_rle ? PH_PACKET : PH_PIXEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hidx_r     <= '0;
      id_left_r  <= '0;
      type_r     <= '0;
      bpp_r      <= '0;
      width_r    <= '0;
      height_r   <= '0;
      col_r      <= '0;
      row_r      <= '0;
      raw_left_r <= '0;
      rep_cnt_r  <= '0;
      is_rep_r   <= 1'b0;
      pbi_r      <= '0;
      asm_r      <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      hidx_r     <= hidx_nxt;
      id_left_r  <= id_left_nxt;
      type_r     <= type_nxt;
      bpp_r      <= bpp_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      raw_left_r <= raw_left_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
      is_rep_r   <= is_rep_nxt;
      pbi_r      <= pbi_nxt;
      asm_r      <= asm_nxt;
    end
  end

  tga_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (accept && res_v),
    .up_data   (res),
    .up_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[hw/rtl/tga_rle_checker.sv]
// Port-level assertions for the TGA run-length stream decoder, bound to its top level.
`default_nettype none

module tga_rle_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire tga_pkg::tga_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire tga_pkg::tga_out_t out_data
);
  import tga_pkg::*;

  // an offered byte holds until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input byte changed before its transfer");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error_code != ERR_NONE) |->
      out_data.last && (out_data.run_length == 8'd0) && (out_data.pixel_value == 24'd0))
    else $error("error transfer not a bare last item");

  a_ovr_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_overrun |-> out_data.end_of_row)
    else $error("overrun without row end");

  a_zero_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.run_length == 8'd0) |-> out_data.last)
    else $error("empty run that is not a final transfer");

endmodule

bind tga_rle_stream_decoder tga_rle_checker u_tga_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

[tb/sv/tga_run_check_pkg.sv]
// Run scoreboard for the TGA stream decoder: byte-level decode of the file and run checks.
package tga_run_check_pkg;
  import tga_pkg::*;

  class tga_run_scoreboard;
    tga_phase_t  phase;
    logic [4:0]  hdr_idx;
    logic [7:0]  id_left;
    logic [7:0]  type_code;
    logic [1:0]  bpp;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [16:0] col_pos;
    logic [15:0] rows_done;
    logic [7:0]  raw_left;
    logic [7:0]  rep_count;
    logic        rep_packet;
    logic [1:0]  pix_idx;
    logic [23:0] pix_acc;

    tga_out_t    expected_runs[$];
    int unsigned runs_checked;
    int unsigned mismatches;
    int unsigned error_items;
    int unsigned image_ends;

    function new();
      restart();
      runs_checked = 0;
      mismatches   = 0;
      error_items  = 0;
      image_ends   = 0;
    endfunction

    function void restart();
      phase      = PH_HEADER;
      hdr_idx    = '0;
      id_left    = '0;
      type_code  = '0;
      bpp        = '0;
      img_width  = '0;
      img_height = '0;
      col_pos    = '0;
      rows_done  = '0;
      raw_left   = '0;
      rep_count  = '0;
      rep_packet = 1'b0;
      pix_idx    = '0;
      pix_acc    = '0;
    endfunction

    function bit is_rle();
      return type_code == TYPE_RLE_TRUE || type_code == TYPE_RLE_GRAY;
    endfunction

    // Clear the per-image counters; an empty image ends here with one item.
    function bit start_data(output tga_out_t run);
      run        = '0;
      col_pos    = '0;
      rows_done  = '0;
      pix_idx    = '0;
      pix_acc    = '0;
      rep_packet = 1'b0;
      raw_left   = '0;
      rep_count  = '0;
      if (img_width == 16'd0 || img_height == 16'd0) begin
        phase    = PH_DONE;
        run.last = 1'b1;
        return 1'b1;
      end
      phase = is_rle() ? PH_PACKET : PH_PIXEL;
      return 1'b0;
    endfunction

    // Advance by one file byte; returns 1 when the byte yields a run.
    function bit decode_byte(tga_in_t item, output tga_out_t run);
      logic [7:0] b;
      logic [4:0] idx;
      logic [7:0] len;
      logic       true_color;
      logic       gray;
      logic       packet_done;
      b   = item.data_byte;
      run = '0;
      if (item.first_byte) restart();
      case (phase)
        PH_HEADER: begin
          idx     = hdr_idx;
          hdr_idx = idx + 5'd1;
          case (idx)
            HDR_ID_LEN:    id_left = b;
            HDR_TYPE:      type_code = b;
            HDR_WIDTH_LO:  img_width[7:0] = b;
            HDR_WIDTH_HI:  img_width[15:8] = b;
            HDR_HEIGHT_LO: img_height[7:0] = b;
            HDR_HEIGHT_HI: img_height[15:8] = b;
            HDR_DEPTH:     bpp = (b == DEPTH_24) ? 2'd3 : ((b == DEPTH_8) ? 2'd1 : 2'd0);
            default: ;
          endcase
          if (idx != HDR_LAST) return 1'b0;
          hdr_idx    = '0;
          true_color = type_code == TYPE_TRUE || type_code == TYPE_RLE_TRUE;
          gray       = type_code == TYPE_GRAY || type_code == TYPE_RLE_GRAY;
          if (!true_color && !gray) begin
            phase          = PH_DONE;
            run.error_code = ERR_TYPE;
            run.last       = 1'b1;
            return 1'b1;
          end
          if ((true_color && bpp != 2'd3) || (gray && bpp != 2'd1)) begin
            phase          = PH_DONE;
            run.error_code = ERR_DEPTH;
            run.last       = 1'b1;
            return 1'b1;
          end
          if (id_left != 8'd0) begin
            phase = PH_ID;
            return 1'b0;
          end
          return start_data(run);
        end
        PH_ID: begin
          id_left = id_left - 8'd1;
          if (id_left == 8'd0) return start_data(run);
          return 1'b0;
        end
        PH_PACKET: begin
          len        = {1'b0, b[6:0]} + 8'd1;
          rep_packet = b[7];
          if (b[7]) rep_count = len;
          else raw_left = len;
          pix_idx = '0;
          pix_acc = '0;
          phase   = PH_PIXEL;
          return 1'b0;
        end
        PH_PIXEL: begin
          // file order is B, G, R: little-endian assembly lands R in the top byte
          pix_acc = pix_acc | ({16'd0, b} << (8 * pix_idx));
          pix_idx = pix_idx + 2'd1;
          if (pix_idx < bpp) return 1'b0;
          run.pixel_value = pix_acc;
          pix_idx = '0;
          pix_acc = '0;
          if (rep_packet) begin
            len         = rep_count;
            packet_done = 1'b1;
          end else begin
            len         = 8'd1;
            packet_done = 1'b1;
            if (is_rle()) begin
              raw_left    = raw_left - 8'd1;
              packet_done = raw_left == 8'd0;
            end
          end
          col_pos            = col_pos + {9'd0, len};
          run.run_length     = len;
          run.end_of_row     = col_pos >= {1'b0, img_width};
          run.packet_overrun = col_pos > {1'b0, img_width};
          if (packet_done) begin
            // overshoot past the row end is dropped
            if (run.end_of_row) begin
              col_pos   = '0;
              rows_done = rows_done + 16'd1;
              run.last  = rows_done >= img_height;
            end
            phase = run.last ? PH_DONE : (is_rle() ? PH_PACKET : PH_PIXEL);
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_byte(tga_in_t item);
      tga_out_t run;
      if (decode_byte(item, run)) expected_runs.push_back(run);
    endfunction

    function void check_run(tga_out_t got);
      tga_out_t want;
      runs_checked++;
      if (expected_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: run %0d with none pending: pix=%06h len=%0d eor=%0b ovr=%0b err=%0d last=%0b",
                   runs_checked, got.pixel_value, got.run_length, got.end_of_row,
                   got.packet_overrun, got.error_code, got.last);
        return;
      end
      want = expected_runs.pop_front();
      if (want.error_code != ERR_NONE) error_items++;
      if (want.last) image_ends++;
      if (got.pixel_value !== want.pixel_value || got.run_length !== want.run_length ||
          got.end_of_row !== want.end_of_row || got.packet_overrun !== want.packet_overrun ||
          got.error_code !== want.error_code || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: run %0d expected pix=%06h len=%0d eor=%0b ovr=%0b err=%0d last=%0b",
                   runs_checked, want.pixel_value, want.run_length, want.end_of_row,
                   want.packet_overrun, want.error_code, want.last);
          $display("       run %0d actual   pix=%06h len=%0d eor=%0b ovr=%0b err=%0d last=%0b",
                   runs_checked, got.pixel_value, got.run_length, got.end_of_row,
                   got.packet_overrun, got.error_code, got.last);
        end
      end
    endfunction
  endclass

endpackage

[tb/sv/tb.sv]
// Self-checking testbench for the TGA run-length stream decoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tga_pkg::*;
  import tga_run_check_pkg::*;

  localparam int ITEM_TARGET     = 1100;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 16;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tga_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tga_out_t out_data;

  tga_run_scoreboard runs_sb    = new();
  tga_run_scoreboard stim_model = new();

  int unsigned items_counted  = 0;
  int unsigned headers_sent   = 0;
  int          quiet_cycles   = 0;
  int          src_gap_pct    = 0;
  int          sink_gap_pct   = 20;
  bit          calm           = 1'b0;
  bit          hold_off_armed = 1'b0;
  bit          hold_off_now   = 1'b0;

  tga_rle_stream_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) runs_sb.note_byte(in_data);
    if (rst_n && out_valid && out_ready) runs_sb.check_run(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d runs still pending",
               quiet_cycles, runs_sb.expected_runs.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one file byte and hold it until the transfer.
  task automatic send_byte(input logic [7:0] b, input logic mark);
    tga_in_t  item;
    tga_out_t discard;
    int       gap;
    item.data_byte  = b;
    item.first_byte = mark;
    if (!(stim_model.phase == PH_DONE && !mark)) items_counted++;
    void'(stim_model.decode_byte(item, discard));
    calm = items_counted >= ITEM_TARGET * 9 / 10;
    if (!hold_off_armed && items_counted >= 400 && stim_model.phase == PH_PIXEL) begin
      hold_off_armed = 1'b1;
      hold_off_now   = 1'b1;
    end
    if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Colour-map and origin fields are random: the block ignores them.
  task automatic send_header(input logic [7:0] img_type, input logic [7:0] depth,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] id_len, input logic mark);
    logic [7:0] hdr [0:17];
    int         i;
    for (i = 0; i < 18; i++) hdr[i] = 8'($urandom);
    hdr[HDR_ID_LEN]    = id_len;
    hdr[HDR_TYPE]      = img_type;
    hdr[HDR_WIDTH_LO]  = w[7:0];
    hdr[HDR_WIDTH_HI]  = w[15:8];
    hdr[HDR_HEIGHT_LO] = h[7:0];
    hdr[HDR_HEIGHT_HI] = h[15:8];
    hdr[HDR_DEPTH]     = depth;
    headers_sent++;
    send_byte(hdr[0], mark);
    for (i = 1; i < 18; i++) send_byte(hdr[i], 1'b0);
  endtask

  // Header, then ID and pixel data steered by the decoder state until done or cut.
  task automatic send_image(input logic [7:0] img_type, input logic [7:0] depth,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [7:0] id_len, input logic mark, input int cap);
    int         n;
    logic [7:0] b;
    send_header(img_type, depth, w, h, id_len, mark);
    n = 0;
    while (stim_model.phase != PH_DONE && n < cap) begin
      b = 8'($urandom);
      if (stim_model.phase == PH_PACKET) begin
        // mostly short packets so rows end often; now and then the longest
        case ($urandom_range(0, 9))
          0:       b[6:0] = (b[7] || $urandom_range(0, 3) == 0) ? 7'h7F : 7'd0;
          1, 2:    b[6:0] = b[7] ? b[6:0] : 7'($urandom_range(0, 12));
          default: b[6:0] = 7'($urandom_range(0, 4));
        endcase
      end
      send_byte(b, 1'b0);
      n++;
    end
  endtask

  initial begin : sink
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_now) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_now = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < sink_gap_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) begin
        case ($urandom_range(0, 2))
          0:       sink_gap_pct = 0;
          1:       sink_gap_pct = 15;
          default: sink_gap_pct = 40;
        endcase
      end
    end
  end

  initial begin : source
    logic [7:0]  img_type;
    logic [7:0]  depth;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  id_len;
    int          kind;
    int          cap;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Header parsed without a start mark right after reset: unsupported type.
    send_header(8'h00, DEPTH_24, 16'd1, 16'd1, 8'd0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // Gray RLE 3x2 with ID bytes: repeat to row end, raw pair, then a 128 repeat past it.
    send_header(TYPE_RLE_GRAY, DEPTH_8, 16'd3, 16'd2, 8'd2, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b0);
    // True-color RLE 1x1 raw pixel: check the BGR to RGB swap.
    send_header(TYPE_RLE_TRUE, DEPTH_24, 16'd1, 16'd1, 8'd0, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_image(TYPE_TRUE, DEPTH_24, 16'd2, 16'd1, 8'd0, 1'b1, 64);
    send_image(TYPE_GRAY, DEPTH_8, 16'd1, 16'd1, 8'd0, 1'b1, 64);
    send_header(TYPE_TRUE, DEPTH_8, 16'd1, 16'd1, 8'd0, 1'b1);
    send_header(8'hFF, DEPTH_8, 16'd1, 16'd1, 8'd0, 1'b1);
    send_header(TYPE_GRAY, DEPTH_8, 16'hFFFF, 16'd0, 8'd0, 1'b1);
    send_image(TYPE_RLE_TRUE, DEPTH_24, 16'd0, 16'hFFFF, 8'hFF, 1'b1, 300);

    while (items_counted < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0:       src_gap_pct = 10;
        1:       src_gap_pct = 30;
        default: src_gap_pct = 0;
      endcase
      case ($urandom_range(0, 3))
        0:       img_type = TYPE_TRUE;
        1:       img_type = TYPE_GRAY;
        2:       img_type = TYPE_RLE_TRUE;
        default: img_type = TYPE_RLE_GRAY;
      endcase
      depth = (img_type == TYPE_TRUE || img_type == TYPE_RLE_TRUE) ? DEPTH_24 : DEPTH_8;
      case ($urandom_range(0, 19))
        0:             id_len = 8'($urandom);
        1, 2, 3, 4, 5: id_len = 8'($urandom_range(1, 4));
        default:       id_len = 8'd0;
      endcase
      case ($urandom_range(0, 9))
        0:       w = 16'($urandom_range(7, 40));
        1:       w = 16'($urandom);
        default: w = 16'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0:       h = 16'($urandom_range(5, 12));
        1:       h = 16'($urandom);
        default: h = 16'($urandom_range(1, 4));
      endcase
      cap  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : 240;
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        do img_type = 8'($urandom);
        while (img_type == TYPE_TRUE || img_type == TYPE_GRAY ||
               img_type == TYPE_RLE_TRUE || img_type == TYPE_RLE_GRAY);
        send_image(img_type, 8'($urandom), w, h, id_len, 1'b1, cap);
      end else if (kind < 11) begin
        if ($urandom_range(0, 1) == 0) begin
          depth = (depth == DEPTH_24) ? DEPTH_8 : DEPTH_24;
        end else begin
          do depth = 8'($urandom);
          while (depth == ((img_type == TYPE_TRUE || img_type == TYPE_RLE_TRUE) ?
                           DEPTH_24 : DEPTH_8));
        end
        send_image(img_type, depth, w, h, id_len, 1'b1, cap);
      end else if (kind < 15) begin
        if ($urandom_range(0, 1) == 0) w = 16'd0;
        else h = 16'd0;
        send_image(img_type, depth, w, h, id_len, 1'b1, cap);
      end else if (kind < 21) begin
        // stray bytes, now and then with a start mark mid-stream
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        send_image(img_type, depth, w, h, id_len, kind >= 26, cap);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (runs_sb.expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d file bytes over %0d headers; %0d runs checked, %0d error items,",
             items_counted, headers_sent, runs_sb.runs_checked, runs_sb.error_items);
    $display("         %0d image ends; output held off %0d cycles mid-image; %0d mismatches",
             runs_sb.image_ends, hold_off_armed ? HOLD_OFF_CYCLES : 0, runs_sb.mismatches);
    if (runs_sb.mismatches == 0 && runs_sb.expected_runs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
